/* rtl/core/gpthc_pkg.sv */
// Package for the GPT header checker: item types, codes, constants and CRC32 step.
`timescale 1ns / 1ps

package gpthc_pkg;

    // Header geometry
    localparam int HEADER_BYTES = 92;
    localparam int OFF_W        = 7;
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(HEADER_BYTES - 1);

    // CRC32 (reflected) and field constants
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] GPT_REVISION = 32'h0001_0000;

    // "EFI PART" in disk order
    localparam logic [7:0] EFI_SIG [8] = '{
        8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54
    };

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_HEADER_CHECK = 2'd0,
        CFG_CRC_CHECK    = 2'd1,
        CFG_TABLE_CHECK  = 2'd2,
        CFG_BACKUP_CHECK = 2'd3
    } t_cfg_reg;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SIGNATURE  = 3'd1,
        ST_REVISION   = 3'd2,
        ST_CRC        = 3'd3,
        ST_NO_ENTRIES = 3'd4,
        ST_ENTRY_LBA  = 3'd5,
        ST_NO_BACKUP  = 3'd6,
        ST_BACKUP_SIG = 3'd7
    } t_status;

    // Input item: one header byte
    typedef struct packed {
        logic       mode;
        logic [7:0] header_byte;
        logic       first;
    } t_in_item;

    // Result item: one verdict per header
    typedef struct packed {
        logic [2:0]  status;
        logic        hdr_ok;
        logic        crc_match;
        logic        table_valid;
        logic        backup_ok;
        logic [63:0] next_lba;
        logic [31:0] crc_result;
    } t_out_item;

    // One byte of reflected CRC32, bit by bit
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/gpt_header_checker_unit.sv */
// Top level of the GPT header checker: byte capture, CRC32 and verdict.
`timescale 1ns / 1ps

// Takes one header byte per cycle and returns one verdict item after the last
// byte (offset HEADER_BYTES-1, 91 by default). Each byte is held in an input
// register, then a byte-wide unrolled CRC32 step and the field capture update
// the header state; the verdict is registered in the output register. Bytes
// keep flowing while a verdict waits to be taken; only a last byte waits for a
// full, stalled output register. first=1 restarts a header at offset zero. The
// user must write the four enable bits through the plain write port only while
// the block is idle; the block itself does not enforce this.
module gpt_header_checker_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic                 i_cfg_data,
    // header bytes in
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  gpthc_pkg::t_in_item  i_in_item,
    // verdicts out
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output gpthc_pkg::t_out_item o_out_item
);

    // Configuration registers
    logic r_en_header;
    logic r_en_crc;
    logic r_en_table;
    logic r_en_backup;

    // Input stage
    logic                r_in_valid;
    gpthc_pkg::t_in_item r_in_item;

    // Header state
    logic [gpthc_pkg::OFF_W-1:0] r_byte_offset;
    logic [31:0] r_running_crc;
    logic [31:0] r_stored_crc;
    logic        r_signature_ok;
    logic [31:0] r_revision_word;
    logic [63:0] r_entry_table_lba;
    logic [31:0] r_entry_count;
    logic [63:0] r_backup_header_lba;

    // Next header state
    logic [31:0] n_running_crc;
    logic [31:0] n_stored_crc;
    logic        n_signature_ok;
    logic [31:0] n_revision_word;
    logic [63:0] n_entry_table_lba;
    logic [31:0] n_entry_count;
    logic [63:0] n_backup_header_lba;

    // Output stage
    logic                 r_out_valid;
    gpthc_pkg::t_out_item r_out_item;
    gpthc_pkg::t_out_item n_out_item;

    logic [gpthc_pkg::OFF_W-1:0] s_off;
    logic [7:0]  s_crc_in;
    logic [31:0] s_final_crc;
    logic        s_last;
    logic        s_advance;
    logic        s_done;
    logic        in_accept;
    logic        out_take;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_header <= 1'b1;
            r_en_crc    <= 1'b1;
            r_en_table  <= 1'b1;
            r_en_backup <= 1'b0;
        end else if (i_cfg_we) begin
            case (gpthc_pkg::t_cfg_reg'(i_cfg_index))
                gpthc_pkg::CFG_HEADER_CHECK: r_en_header <= i_cfg_data;
                gpthc_pkg::CFG_CRC_CHECK:    r_en_crc    <= i_cfg_data;
                gpthc_pkg::CFG_TABLE_CHECK:  r_en_table  <= i_cfg_data;
                gpthc_pkg::CFG_BACKUP_CHECK: r_en_backup <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: only a last byte can be held back by a stalled result
    assign out_take   = r_out_valid && !i_out_stall;
    assign s_advance  = r_in_valid && (!s_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Byte processing: field capture and CRC step
    always_comb begin
        s_off               = r_in_item.first ? '0 : r_byte_offset;
        n_running_crc       = r_in_item.first ? gpthc_pkg::CRC_INIT : r_running_crc;
        n_stored_crc        = r_in_item.first ? '0 : r_stored_crc;
        n_signature_ok      = r_in_item.first ? 1'b1 : r_signature_ok;
        n_revision_word     = r_in_item.first ? '0 : r_revision_word;
        n_entry_table_lba   = r_in_item.first ? '0 : r_entry_table_lba;
        n_entry_count       = r_in_item.first ? '0 : r_entry_count;
        n_backup_header_lba = r_in_item.first ? '0 : r_backup_header_lba;
        s_crc_in            = r_in_item.header_byte;

        case (s_off) inside
            [7'd0:7'd7]: begin
                if (r_in_item.header_byte != gpthc_pkg::EFI_SIG[s_off[2:0]]) begin
                    n_signature_ok = 1'b0;
                end
            end
            [7'd8:7'd11]: n_revision_word[{s_off[1:0], 3'b000} +: 8] = r_in_item.header_byte;
            [7'd16:7'd19]: begin
                // stored CRC field enters the CRC as zero
                n_stored_crc[{s_off[1:0], 3'b000} +: 8] = r_in_item.header_byte;
                s_crc_in = 8'd0;
            end
            [7'd32:7'd39]: begin
                n_backup_header_lba[{s_off[2:0], 3'b000} +: 8] = r_in_item.header_byte;
            end
            [7'd72:7'd79]: begin
                n_entry_table_lba[{s_off[2:0], 3'b000} +: 8] = r_in_item.header_byte;
            end
            [7'd80:7'd83]: n_entry_count[{s_off[1:0], 3'b000} +: 8] = r_in_item.header_byte;
            default: ;
        endcase

        n_running_crc = gpthc_pkg::crc32_byte(n_running_crc, s_crc_in);
        s_final_crc   = ~n_running_crc;
        s_last        = (s_off == gpthc_pkg::OFF_LAST);
    end

    // Verdict: first failing check wins
    always_comb begin
        n_out_item            = '0;
        n_out_item.crc_result = s_final_crc;
        n_out_item.status     = gpthc_pkg::ST_OK;
        s_done                = 1'b0;
        if (r_in_item.mode) begin
            // backup header: signature only
            n_out_item.backup_ok = n_signature_ok;
            if (!n_signature_ok) n_out_item.status = gpthc_pkg::ST_BACKUP_SIG;
        end else begin
            n_out_item.hdr_ok   = 1'b1;
            n_out_item.next_lba = n_backup_header_lba;
            if (r_en_header) begin
                if (!n_signature_ok) begin
                    n_out_item.status = gpthc_pkg::ST_SIGNATURE;
                    n_out_item.hdr_ok = 1'b0;
                    s_done            = 1'b1;
                end else if (n_revision_word != gpthc_pkg::GPT_REVISION) begin
                    n_out_item.status = gpthc_pkg::ST_REVISION;
                    n_out_item.hdr_ok = 1'b0;
                    s_done            = 1'b1;
                end
            end
            if (!s_done && r_en_crc) begin
                if (s_final_crc != n_stored_crc) begin
                    n_out_item.status = gpthc_pkg::ST_CRC;
                    s_done            = 1'b1;
                end else begin
                    n_out_item.crc_match = 1'b1;
                end
            end
            if (!s_done && r_en_table) begin
                if (n_entry_count == '0) begin
                    n_out_item.status = gpthc_pkg::ST_NO_ENTRIES;
                    s_done            = 1'b1;
                end else if (n_entry_table_lba == '0) begin
                    n_out_item.status = gpthc_pkg::ST_ENTRY_LBA;
                    s_done            = 1'b1;
                end else begin
                    n_out_item.table_valid = 1'b1;
                end
            end
            if (!s_done && r_en_backup) begin
                if (n_backup_header_lba == '0) begin
                    n_out_item.status = gpthc_pkg::ST_NO_BACKUP;
                end else begin
                    n_out_item.backup_ok = 1'b1;
                end
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (s_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) r_in_item <= i_in_item;
    end

    // Header state; returns to start values after a verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s_advance && s_last)) begin
            r_byte_offset       <= '0;
            r_running_crc       <= gpthc_pkg::CRC_INIT;
            r_stored_crc        <= '0;
            r_signature_ok      <= 1'b1;
            r_revision_word     <= '0;
            r_entry_table_lba   <= '0;
            r_entry_count       <= '0;
            r_backup_header_lba <= '0;
        end else if (s_advance) begin
            r_byte_offset       <= s_off + 1'b1;
            r_running_crc       <= n_running_crc;
            r_stored_crc        <= n_stored_crc;
            r_signature_ok      <= n_signature_ok;
            r_revision_word     <= n_revision_word;
            r_entry_table_lba   <= n_entry_table_lba;
            r_entry_count       <= n_entry_count;
            r_backup_header_lba <= n_backup_header_lba;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance && s_last) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance && s_last) r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A verdict never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_advance && s_last) |-> !(r_out_valid && i_out_stall))
        else $error("verdict overwrote a pending result");

    // Offset never runs past the last header byte
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_offset <= gpthc_pkg::OFF_LAST)
        else $error("byte offset out of range");

    // Input stalls only behind a last byte waiting on the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && s_last && r_out_valid && i_out_stall))
        else $error("input stalled without a pending verdict");

    // After a verdict is produced the header state is back at its start
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_advance && s_last) |=> (r_byte_offset == '0 &&
                                   r_running_crc == gpthc_pkg::CRC_INIT))
        else $error("header state not restarted after verdict");

endmodule

/* dv/gpt_header_checker_checker.sv */
// Checker for the GPT header checker: CRC helper, verdict predictor and comparison.
`timescale 1ns / 1ps

package gpthc_dv_pkg;

    import gpthc_pkg::*;

    // One byte into a reflected CRC32, LSB first
    function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r  = (r >> 1) ^ (fb ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

endpackage

module gpt_header_checker_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  gpthc_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  gpthc_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending
);

    import gpthc_pkg::*;
    import gpthc_dv_pkg::*;

    // Check enables, as last written
    logic chk_hdr, chk_crc, chk_tbl, chk_bak;

    // Header being assembled
    logic [OFF_W-1:0] hdr_pos;
    logic [31:0]      crc_run;
    logic [31:0]      crc_stored;
    logic             sig_match;
    logic [31:0]      rev_word;
    logic [63:0]      tbl_lba;
    logic [31:0]      ent_count;
    logic [63:0]      bak_lba;

    t_out_item verdict_q[$];
    int        n_mismatch = 0;

    task automatic begin_header();
        hdr_pos    = '0;
        crc_run    = CRC_INIT;
        crc_stored = '0;
        sig_match  = 1'b1;
        rev_word   = '0;
        tbl_lba    = '0;
        ent_count  = '0;
        bak_lba    = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        n_mismatch++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Fold one accepted byte into the header; queue a verdict on the last byte
    task automatic absorb_byte(input t_in_item it);
        int          pos;
        logic [7:0]  crc_in;
        t_out_item   v;
        bit          decided;
        if (it.first) begin
            begin_header();
        end
        pos    = int'(hdr_pos);
        crc_in = it.header_byte;
        if (pos < 8) begin
            if (it.header_byte != EFI_SIG[pos]) sig_match = 1'b0;
        end else if (pos < 12) begin
            rev_word[8*(pos-8) +: 8] = it.header_byte;
        end else if (pos >= 16 && pos < 20) begin
            crc_stored[8*(pos-16) +: 8] = it.header_byte;
            crc_in = '0;    // CRC field counts as zero
        end else if (pos >= 32 && pos < 40) begin
            bak_lba[8*(pos-32) +: 8] = it.header_byte;
        end else if (pos >= 72 && pos < 80) begin
            tbl_lba[8*(pos-72) +: 8] = it.header_byte;
        end else if (pos >= 80 && pos < 84) begin
            ent_count[8*(pos-80) +: 8] = it.header_byte;
        end
        crc_run = crc_fold(crc_run, crc_in);

        if (pos < HEADER_BYTES - 1) begin
            hdr_pos = OFF_W'(pos + 1);
        end else begin
            v = '0;
            v.crc_result = ~crc_run;
            if (it.mode) begin
                // backup header: signature only
                v.backup_ok = sig_match;
                v.status    = sig_match ? ST_OK : ST_BACKUP_SIG;
            end else begin
                decided    = 1'b0;
                v.hdr_ok   = 1'b1;
                v.next_lba = bak_lba;
                if (chk_hdr) begin
                    if (!sig_match) begin
                        v.status = ST_SIGNATURE; v.hdr_ok = 1'b0; decided = 1'b1;
                    end else if (rev_word != GPT_REVISION) begin
                        v.status = ST_REVISION; v.hdr_ok = 1'b0; decided = 1'b1;
                    end
                end
                if (!decided && chk_crc) begin
                    if (~crc_run != crc_stored) begin
                        v.status = ST_CRC; decided = 1'b1;
                    end else begin
                        v.crc_match = 1'b1;
                    end
                end
                if (!decided && chk_tbl) begin
                    if (ent_count == '0) begin
                        v.status = ST_NO_ENTRIES; decided = 1'b1;
                    end else if (tbl_lba == '0) begin
                        v.status = ST_ENTRY_LBA; decided = 1'b1;
                    end else begin
                        v.table_valid = 1'b1;
                    end
                end
                if (!decided && chk_bak) begin
                    if (bak_lba == '0) v.status = ST_NO_BACKUP;
                    else v.backup_ok = 1'b1;
                end
            end
            verdict_q.push_back(v);
            begin_header();
        end
    endtask

    // Watch config writes, verdicts and bytes at each edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            chk_hdr = 1'b1;
            chk_crc = 1'b1;
            chk_tbl = 1'b1;
            chk_bak = 1'b0;
            begin_header();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_HEADER_CHECK: chk_hdr = i_cfg_data;
                    CFG_CRC_CHECK:    chk_crc = i_cfg_data;
                    CFG_TABLE_CHECK:  chk_tbl = i_cfg_data;
                    CFG_BACKUP_CHECK: chk_bak = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict with none pending", 64'(i_out_item.status), '0);
                end else begin
                    want = verdict_q.pop_front();
                    check_field("status", 64'(i_out_item.status), 64'(want.status));
                    check_field("hdr_ok", 64'(i_out_item.hdr_ok), 64'(want.hdr_ok));
                    check_field("crc_match", 64'(i_out_item.crc_match),
                                64'(want.crc_match));
                    check_field("table_valid", 64'(i_out_item.table_valid),
                                64'(want.table_valid));
                    check_field("backup_ok", 64'(i_out_item.backup_ok),
                                64'(want.backup_ok));
                    check_field("next_lba", i_out_item.next_lba, want.next_lba);
                    check_field("crc_result", 64'(i_out_item.crc_result),
                                64'(want.crc_result));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_byte(i_in_item);
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= n_mismatch;
    end

endmodule

/* dv/gpt_header_checker_unit_tb.sv */
// Testbench top for the GPT header checker: clock, reset, header stimulus and verdict.
`timescale 1ns / 1ps

module gpt_header_checker_unit_tb;

    import gpthc_pkg::*;
    import gpthc_dv_pkg::*;

    // Header defects to plant
    typedef struct packed {
        bit sig;
        bit rev;
        bit crc;
        bit no_count;
        bit no_lba;
        bit no_backup;
    } t_defects;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic       i_cfg_data  = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_stall = 1'b0;
    t_in_item   i_in_item   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    int         fail_count;
    int         pending;

    bit         no_gaps = 1'b0;
    logic [7:0] hdr [HEADER_BYTES];
    int         bytes_sent   = 0;
    bit         aligned      = 1'b1;

    gpt_header_checker_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    gpt_header_checker_checker i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Random back-pressure on verdicts
    always @(posedge i_clk) begin
        i_out_stall <= !no_gaps && ($urandom_range(0, 99) < 20);
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic write_reg(input t_cfg_reg idx, input bit v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
    endtask

    task automatic cfg_write(input bit hdr_en, input bit crc_en, input bit tbl_en,
                             input bit bak_en);
        write_reg(CFG_HEADER_CHECK, hdr_en);
        write_reg(CFG_CRC_CHECK, crc_en);
        write_reg(CFG_TABLE_CHECK, tbl_en);
        write_reg(CFG_BACKUP_CHECK, bak_en);
        i_cfg_we <= 1'b0;
    endtask

    // Stop sending, let every verdict arrive, then allow the pipeline to settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_byte(input bit m, input logic [7:0] b, input bit f);
        t_in_item it;
        it.mode        = m;
        it.header_byte = b;
        it.first       = f;
        if (!no_gaps && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // Send hdr[0..len-1]; earlier mode bits random when mix is set
    task automatic send_header(input bit m, input bit mark, input bit mix, input int len);
        for (int i = 0; i < len; i++) begin
            push_byte((i == len - 1 || !mix) ? m : bit'($urandom_range(0, 1)), hdr[i],
                      (i == 0) ? mark : 1'b0);
        end
        aligned = (len == HEADER_BYTES);
    endtask

    task automatic put_field(input int at, input int nbytes, input logic [63:0] v);
        for (int k = 0; k < nbytes; k++) begin
            hdr[at + k] = v[8*k +: 8];
        end
    endtask

    // Nonzero value, often with only the top or bottom byte set
    function automatic logic [63:0] rand_nonzero(input int nbytes);
        logic [63:0] v;
        int          pick;
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            v = 64'($urandom_range(1, 255)) << (8 * (nbytes - 1));
        end else if (pick == 1) begin
            v = 64'($urandom_range(1, 255));
        end else begin
            v = {$urandom, $urandom};
            if (nbytes < 8) v = v & ((64'd1 << (8 * nbytes)) - 1);
            if (v == '0) v = 64'd1;
        end
        return v;
    endfunction

    task automatic flip_bit(input int lo, input int hi);
        int k;
        k = $urandom_range(lo, hi);
        hdr[k] = hdr[k] ^ (8'h01 << $urandom_range(0, 7));
    endtask

    // Store the CRC over the header with its CRC field zeroed
    task automatic seal_crc(input bit spoil);
        logic [31:0] c;
        put_field(16, 4, '0);
        c = CRC_INIT;
        for (int i = 0; i < HEADER_BYTES; i++) c = crc_fold(c, hdr[i]);
        put_field(16, 4, 64'(~c));
        if (spoil) flip_bit(16, 19);
    endtask

    task automatic make_header(input t_defects d);
        foreach (hdr[i]) hdr[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 8; i++) hdr[i] = EFI_SIG[i];
        put_field(8, 4, 64'(GPT_REVISION));
        put_field(32, 8, d.no_backup ? 64'd0 : rand_nonzero(8));
        put_field(72, 8, d.no_lba ? 64'd0 : rand_nonzero(8));
        put_field(80, 4, d.no_count ? 64'd0 : rand_nonzero(4));
        if (d.sig) flip_bit(0, 7);
        if (d.rev) flip_bit(8, 11);
        seal_crc(d.crc);
    endtask

    function automatic t_defects rand_defects();
        t_defects d;
        d = '0;
        if ($urandom_range(0, 99) < 45) begin
            d.sig       = $urandom_range(0, 99) < 20;
            d.rev       = $urandom_range(0, 99) < 20;
            d.crc       = $urandom_range(0, 99) < 25;
            d.no_count  = $urandom_range(0, 99) < 20;
            d.no_lba    = $urandom_range(0, 99) < 20;
            d.no_backup = $urandom_range(0, 99) < 30;
        end
        return d;
    endfunction

    // Mostly well-formed headers, some cut short, some raw noise
    task automatic random_step();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 72) begin
            make_header(rand_defects());
            send_header($urandom_range(0, 99) < 20, !aligned || $urandom_range(0, 99) < 85,
                        $urandom_range(0, 99) < 25, HEADER_BYTES);
        end else if (r < 86) begin
            make_header(rand_defects());
            send_header(1'b0, 1'b1, 1'b1, $urandom_range(1, HEADER_BYTES - 1));
        end else begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) begin
                push_byte(bit'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          $urandom_range(0, 99) < 3);
            end
            aligned = 1'b0;
        end
    endtask

    initial begin
        t_defects d;
        int       phase;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every check on
        cfg_write(1'b1, 1'b1, 1'b1, 1'b1);
        d = '0; make_header(d); send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        d = '0; d.sig = 1'b1;       make_header(d); send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        d = '0; d.rev = 1'b1;       make_header(d); send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        d = '0; d.crc = 1'b1;       make_header(d); send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        d = '0; d.no_count = 1'b1;  make_header(d); send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        d = '0; d.no_lba = 1'b1;    make_header(d); send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        d = '0; d.no_backup = 1'b1; make_header(d); send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        // backup header, good and bad signature
        d = '0; make_header(d); send_header(1'b1, 1'b1, 1'b0, HEADER_BYTES);
        d = '0; d.sig = 1'b1; make_header(d); send_header(1'b1, 1'b1, 1'b0, HEADER_BYTES);
        // mode bits of earlier bytes toggle
        d = '0; make_header(d); send_header(1'b0, 1'b1, 1'b1, HEADER_BYTES);
        // next header without a first mark
        d = '0; make_header(d); send_header(1'b0, 1'b0, 1'b0, HEADER_BYTES);
        // restart in mid-header
        d = '0; make_header(d); send_header(1'b0, 1'b1, 1'b0, 40);
        d = '0; make_header(d); send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        // byte extremes
        foreach (hdr[i]) hdr[i] = 8'hFF;
        send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        foreach (hdr[i]) hdr[i] = 8'h00;
        send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        send_header(1'b1, 1'b1, 1'b0, HEADER_BYTES);
        drain();

        // Directed: every check off
        cfg_write(1'b0, 1'b0, 1'b0, 1'b0);
        d = '0; d.sig = 1'b1; d.crc = 1'b1; make_header(d);
        send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        foreach (hdr[i]) hdr[i] = 8'h00;
        send_header(1'b0, 1'b1, 1'b0, HEADER_BYTES);
        d = '0; d.sig = 1'b1; make_header(d); send_header(1'b1, 1'b1, 1'b0, HEADER_BYTES);
        drain();

        // Random phases, each under its own enables
        phase = 0;
        while (phase < 4 || bytes_sent < 1900) begin
            if (phase == 0) cfg_write(1'b1, 1'b1, 1'b1, 1'b0);
            else if (phase == 1) cfg_write(1'b1, 1'b1, 1'b1, 1'b1);
            else cfg_write(bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
                           bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
            no_gaps = (phase == 2);
            repeat ($urandom_range(1, 2)) random_step();
            drain();
            no_gaps = 1'b0;
            phase++;
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* gpt_header_checker_unit.f */
rtl/core/gpthc_pkg.sv
rtl/core/gpt_header_checker_unit.sv
dv/gpt_header_checker_checker.sv
dv/gpt_header_checker_unit_tb.sv
